// ===== rtl/core/lru_key_value_cache_unit_defines.svh =====
// Assertion macros for the LRU key-value cache.
`ifndef LRU_KEY_VALUE_CACHE_UNIT_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define LKVC_ASSERT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lkvc assertion failed");
`define LKVC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lkvc assertion failed");
`else
`define LKVC_ASSERT(label, clk, rst_n, ante, cons)
`define LKVC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/lkvc_pkg.sv =====
`timescale 1ns / 1ps
package lkvc_pkg;
	localparam int CAP_W = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
	localparam logic signed [31:0] MISS_VALUE = -32'sd1;

	typedef enum logic {
		OP_GET = 1'b0,
		OP_PUT = 1'b1
	} op_t;

	typedef struct packed {
		op_t operation;
		logic signed [31:0] key;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic hit;
		logic signed [31:0] result_value;
	} rsp_t;
endpackage

// ===== rtl/core/lkvc_ram.sv =====
`timescale 1ns / 1ps
module lkvc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/core/lru_key_value_cache_unit.sv =====
// LRU key-value cache: keys, values and recency ranks live in three RAMs.
// From acceptance to the result register, a get that misses passes scan, decide and finish;
// a hit or a put also passes the update state between decide and finish.
// A new transaction is taken only when the last one is done; all but
// a missed get walk the rank RAM twice, and a result not yet taken holds the next one back.
// Reset clears valid marks and occupancy and sets capacity to 16; RAMs are not cleared.
`timescale 1ns / 1ps
`include "lru_key_value_cache_unit_defines.svh"
module lru_key_value_cache_unit #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [4:0]      cfg_wdata,
	input  logic            in_valid,
	output logic            in_ready,
	input  lkvc_pkg::req_t  in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output lkvc_pkg::rsp_t  out_data
);
	import lkvc_pkg::*;

	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_UPDATE,
		ST_FINISH
	} state_t;

	state_t state_q;
	req_t req_q;
	logic [CW-1:0] rd_cnt_q;
	logic rd_v_s1;
	logic [IW-1:0] rd_idx_s1;
	logic [MAX_ENTRIES-1:0] valid_q;
	logic [CW-1:0] occ_q;
	logic [CAP_W-1:0] cap_q;
	logic hit_q;
	logic [IW-1:0] hit_idx_q;
	logic [IW-1:0] hit_rank_q;
	logic old_found_q;
	logic [IW-1:0] old_idx_q;
	logic [IW-1:0] old_rank_q;
	logic free_found_q;
	logic [IW-1:0] free_idx_q;
	logic [IW-1:0] ins_idx_q;
	logic out_valid_q;
	rsp_t out_data_q;

	logic [31:0] key_rd;
	logic [31:0] val_rd;
	logic [IW-1:0] rank_rd;

	logic issue;
	logic [IW-1:0] rd_addr;
	logic last_s1;
	logic cur_valid;
	logic is_put;
	logic [CMPW-1:0] eff_cap;
	logic evict;
	logic [IW-1:0] ins_idx;
	logic finish_go;
	logic miss_put;
	logic mem_we;
	logic [IW-1:0] mem_waddr;
	logic rank_we;
	logic [IW-1:0] rank_waddr;
	logic [IW-1:0] rank_wdata;
	rsp_t rsp;

	assign issue = (state_q == ST_SCAN || state_q == ST_UPDATE) &&
		(rd_cnt_q < CW'(MAX_ENTRIES));
	assign rd_addr = rd_cnt_q[IW-1:0];
	assign last_s1 = rd_v_s1 && (rd_idx_s1 == IW'(MAX_ENTRIES - 1));
	assign cur_valid = valid_q[rd_idx_s1];
	assign is_put = (req_q.operation == OP_PUT);
	assign miss_put = is_put && !hit_q;
	assign finish_go = (state_q == ST_FINISH) && (!out_valid_q || out_ready);

	always_comb begin
		if (cap_q == '0) begin
			eff_cap = CMPW'(1);
		end else if (CMPW'(cap_q) > CMPW'(MAX_ENTRIES)) begin
			eff_cap = CMPW'(MAX_ENTRIES);
		end else begin
			eff_cap = CMPW'(cap_q);
		end
	end

	assign evict = miss_put && (CMPW'(occ_q) >= eff_cap) && old_found_q;
	assign ins_idx = (evict && (!free_found_q || old_idx_q < free_idx_q)) ?
		old_idx_q : free_idx_q;

	assign mem_we = finish_go && is_put;
	assign mem_waddr = hit_q ? hit_idx_q : ins_idx_q;

	always_comb begin
		rank_we = 1'b0;
		rank_waddr = rd_idx_s1;
		rank_wdata = rank_rd + IW'(1);
		if (state_q == ST_FINISH) begin
			rank_we = finish_go && miss_put;
			rank_waddr = ins_idx_q;
			rank_wdata = '0;
		end else if (state_q == ST_UPDATE && rd_v_s1 && cur_valid) begin
			if (!hit_q) begin
				rank_we = 1'b1;
			end else if (rd_idx_s1 == hit_idx_q) begin
				rank_we = 1'b1;
				rank_wdata = '0;
			end else if (rank_rd < hit_rank_q) begin
				rank_we = 1'b1;
			end
		end
	end

	always_comb begin
		rsp.hit = hit_q;
		if (is_put) begin
			rsp.result_value = '0;
		end else if (hit_q) begin
			rsp.result_value = val_rd;
		end else begin
			rsp.result_value = MISS_VALUE;
		end
	end

	lkvc_ram #(.WIDTH(32), .DEPTH(MAX_ENTRIES)) u_key_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (req_q.key),
		.raddr (rd_addr),
		.rdata (key_rd)
	);

	lkvc_ram #(.WIDTH(32), .DEPTH(MAX_ENTRIES)) u_val_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (req_q.value),
		.raddr (hit_idx_q),
		.rdata (val_rd)
	);

	lkvc_ram #(.WIDTH(IW), .DEPTH(MAX_ENTRIES)) u_rank_ram (
		.clk   (clk),
		.we    (rank_we),
		.waddr (rank_waddr),
		.wdata (rank_wdata),
		.raddr (rd_addr),
		.rdata (rank_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			req_q <= '0;
			rd_cnt_q <= '0;
			rd_v_s1 <= 1'b0;
			rd_idx_s1 <= '0;
			valid_q <= '0;
			occ_q <= '0;
			cap_q <= CAP_RESET;
			hit_q <= 1'b0;
			hit_idx_q <= '0;
			hit_rank_q <= '0;
			old_found_q <= 1'b0;
			old_idx_q <= '0;
			old_rank_q <= '0;
			free_found_q <= 1'b0;
			free_idx_q <= '0;
			ins_idx_q <= '0;
			out_valid_q <= 1'b0;
			out_data_q <= '0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			rd_v_s1 <= issue;
			rd_idx_s1 <= rd_addr;
			if (issue) begin
				rd_cnt_q <= rd_cnt_q + CW'(1);
			end
			if (out_valid_q && out_ready && !finish_go) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						req_q <= in_data;
						rd_cnt_q <= '0;
						hit_q <= 1'b0;
						old_found_q <= 1'b0;
						free_found_q <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_v_s1) begin
						if (cur_valid && key_rd == req_q.key && !hit_q) begin
							hit_q <= 1'b1;
							hit_idx_q <= rd_idx_s1;
							hit_rank_q <= rank_rd;
						end
						if (cur_valid && (!old_found_q || rank_rd > old_rank_q)) begin
							old_found_q <= 1'b1;
							old_idx_q <= rd_idx_s1;
							old_rank_q <= rank_rd;
						end
						if (!cur_valid && !free_found_q) begin
							free_found_q <= 1'b1;
							free_idx_q <= rd_idx_s1;
						end
					end
					if (last_s1) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					rd_cnt_q <= '0;
					ins_idx_q <= ins_idx;
					if (evict) begin
						valid_q[old_idx_q] <= 1'b0;
						occ_q <= occ_q - CW'(1);
					end
					if (!is_put && !hit_q) begin
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					if (last_s1) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (finish_go) begin
						out_valid_q <= 1'b1;
						out_data_q <= rsp;
						if (miss_put) begin
							valid_q[ins_idx_q] <= 1'b1;
							occ_q <= occ_q + CW'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	`LKVC_ASSERT(a_occ_matches_valid, clk, arst_n, 1'b1, occ_q == CW'($countones(valid_q)))
	`LKVC_ASSERT_NEXT(a_accept_starts_scan, clk, arst_n, in_valid && in_ready, state_q == ST_SCAN)
	`LKVC_ASSERT(a_insert_slot_free, clk, arst_n, state_q == ST_FINISH && miss_put, !valid_q[ins_idx_q])
endmodule

// ===== dv/lkvc_checker.sv =====
`timescale 1ns / 1ps
module lkvc_checker #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [lkvc_pkg::CAP_W-1:0]    cfg_wdata,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  lkvc_pkg::req_t                in_data,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  lkvc_pkg::rsp_t                out_data,
	output int                            failures,
	output int                            outstanding,
	output int                            gets,
	output int                            get_hits,
	output int                            puts,
	output int                            put_hits,
	output int                            evictions
);
	import lkvc_pkg::*;

	logic signed [31:0] slot_key [MAX_ENTRIES];
	logic signed [31:0] slot_val [MAX_ENTRIES];
	logic               slot_used [MAX_ENTRIES];
	int unsigned        slot_age [MAX_ENTRIES];
	int unsigned        fill;
	logic [CAP_W-1:0]   cap_reg;
	rsp_t               due_q [$];
	int                 result_no;

	function automatic int unsigned cap_limit();
		int unsigned c;
		c = cap_reg;
		if (c < 1)
			c = 1;
		if (c > MAX_ENTRIES)
			c = MAX_ENTRIES;
		return c;
	endfunction

	function automatic void promote(int idx);
		int unsigned r;
		r = slot_age[idx];
		for (int j = 0; j < MAX_ENTRIES; j++) begin
			if (slot_used[j] && slot_age[j] < r)
				slot_age[j]++;
		end
		slot_age[idx] = 0;
	endfunction

	function automatic void evict_lru();
		int best;
		best = -1;
		for (int j = 0; j < MAX_ENTRIES; j++) begin
			if (slot_used[j] && (best < 0 || slot_age[j] > slot_age[best]))
				best = j;
		end
		if (best >= 0) begin
			slot_used[best] = 1'b0;
			slot_age[best] = 0;
			if (fill > 0)
				fill--;
			evictions++;
		end
	endfunction

	function automatic rsp_t cache_access(req_t r);
		rsp_t res;
		int   idx;
		bit   found;
		idx = 0;
		found = 1'b0;
		for (int j = 0; j < MAX_ENTRIES; j++) begin
			if (!found && slot_used[j] && slot_key[j] == r.key) begin
				idx = j;
				found = 1'b1;
			end
		end
		res.hit = found;
		res.result_value = '0;
		if (r.operation == OP_GET) begin
			gets++;
			if (found) begin
				get_hits++;
				promote(idx);
				res.result_value = slot_val[idx];
			end else begin
				res.result_value = MISS_VALUE;
			end
		end else begin
			puts++;
			if (found) begin
				put_hits++;
				slot_val[idx] = r.value;
				promote(idx);
			end else begin
				if (fill >= cap_limit())
					evict_lru();
				for (int j = 0; j < MAX_ENTRIES; j++) begin
					if (slot_used[j])
						slot_age[j]++;
				end
				found = 1'b0;
				for (int j = 0; j < MAX_ENTRIES; j++) begin
					if (!found && !slot_used[j]) begin
						slot_used[j] = 1'b1;
						slot_key[j] = r.key;
						slot_val[j] = r.value;
						slot_age[j] = 0;
						fill++;
						found = 1'b1;
					end
				end
			end
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			for (int j = 0; j < MAX_ENTRIES; j++) begin
				slot_used[j] = 1'b0;
				slot_age[j] = 0;
			end
			fill = 0;
			cap_reg = CAP_RESET;
			due_q.delete();
			result_no = 0;
			outstanding <= 0;
		end else begin
			if (cfg_we)
				cap_reg = cfg_wdata;
			if (out_valid && out_ready) begin
				if (due_q.size() == 0) begin
					failures++;
					if (failures <= 10)
						$display("lkvc_checker: result %0d arrived with no transaction pending: hit=%0b value=%0d",
							result_no, out_data.hit, out_data.result_value);
				end else begin
					want = due_q.pop_front();
					if (out_data.hit !== want.hit || out_data.result_value !== want.result_value) begin
						failures++;
						if (failures <= 10)
							$display("lkvc_checker: result %0d expected hit=%0b value=%0d, got hit=%0b value=%0d",
								result_no, want.hit, want.result_value,
								out_data.hit, out_data.result_value);
					end
				end
				result_no++;
			end
			if (in_valid && in_ready)
				due_q.push_back(cache_access(in_data));
			outstanding <= due_q.size();
		end
	end
endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
	import lkvc_pkg::*;

	localparam int ENTRIES = 16;
	localparam int CLK_HALF = 10;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 2 * ENTRIES + 15;
	localparam int PHASES = 12;
	localparam int ITEMS_PER_PHASE = 125;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [CAP_W-1:0] cfg_wdata = '0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	req_t             in_data = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	rsp_t             out_data;

	int failures;
	int outstanding;
	int gets;
	int get_hits;
	int puts;
	int put_hits;
	int evictions;

	int                 burst_left = 0;
	bit                 steady = 1'b0;
	logic signed [31:0] key_pool [32];
	int                 pool_size = 1;
	int                 settings_seen = 0;
	int                 quiet = 0;
	int                 rx_cycle = 0;
	int                 rx_mode = 0;

	lru_key_value_cache_unit #(
		.MAX_ENTRIES(ENTRIES)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	lkvc_checker #(
		.MAX_ENTRIES(ENTRIES)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.failures(failures),
		.outstanding(outstanding),
		.gets(gets),
		.get_hits(get_hits),
		.puts(puts),
		.put_hits(put_hits),
		.evictions(evictions)
	);

	always begin
		#(CLK_HALF) clk = 1'b1;
		#(CLK_HALF) clk = 1'b0;
	end

	// The receiver switches at random between full throughput, coin flips, long stalls
	// and a fixed duty cycle.
	always @(negedge clk) begin
		rx_cycle++;
		if (rx_cycle % 400 == 0)
			rx_mode = $urandom_range(0, 3);
		case (rx_mode)
			0: out_ready = 1'b1;
			1: out_ready = $urandom_range(0, 1);
			2: out_ready = ($urandom_range(0, 7) == 0);
			default: out_ready = (rx_cycle % 5) != 0;
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("tb_top: no transaction for %0d cycles", WATCHDOG_LIMIT);
				$display("tb_top: done, errors");
				$finish;
			end
		end
	end

	task automatic drain();
		in_valid = 1'b0;
		wait (outstanding == 0);
		@(negedge clk);
	endtask

	task automatic write_capacity(input int cap);
		cfg_we = 1'b1;
		cfg_wdata = cap[CAP_W-1:0];
		@(negedge clk);
		cfg_we = 1'b0;
		settings_seen++;
	endtask

	task automatic issue(input op_t op, input logic signed [31:0] k, input logic signed [31:0] v);
		if (!steady) begin
			if (burst_left == 0) begin
				in_valid = 1'b0;
				repeat ($urandom_range(1, 14)) @(negedge clk);
				burst_left = $urandom_range(1, 24);
			end
			burst_left--;
		end
		in_data.operation = op;
		in_data.key = k;
		in_data.value = v;
		in_valid = 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return -32'sd1;
			1: return 32'sd0;
			2: return 32'sh7fffffff;
			3: return 32'sh80000000;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int                 caps [PHASES];
		int                 eff;
		int                 pause_at;
		op_t                op;
		logic signed [31:0] k;

		caps = '{16, 1, 0, 31, 3, 17, 8, 2, 5, 12, 16, 0};
		caps[PHASES-1] = $urandom_range(0, 31);
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Eviction at a small capacity, extreme keys and values, and a stored -1.
		write_capacity(2);
		issue(OP_GET, 32'sd0, 32'sd5);
		issue(OP_PUT, 32'sh80000000, 32'sh7fffffff);
		issue(OP_PUT, 32'sh7fffffff, 32'sh80000000);
		issue(OP_GET, 32'sh80000000, 32'sd0);
		issue(OP_PUT, -32'sd1, -32'sd1);
		issue(OP_GET, 32'sh7fffffff, 32'sd0);
		issue(OP_GET, -32'sd1, 32'sd0);
		issue(OP_PUT, -32'sd1, 32'sd0);
		issue(OP_GET, -32'sd1, 32'sd0);
		issue(OP_GET, 32'sh80000000, 32'sd0);
		drain();

		// A zero capacity behaves as one while two entries are still held.
		write_capacity(0);
		issue(OP_GET, -32'sd1, 32'sd0);
		issue(OP_PUT, 32'sd5, 32'sd7);
		issue(OP_GET, 32'sd5, 32'sd0);
		issue(OP_GET, 32'sh80000000, 32'sd0);
		issue(OP_GET, -32'sd1, 32'sd0);
		issue(OP_PUT, 32'sd6, 32'sh7fffffff);
		issue(OP_GET, 32'sd5, 32'sd0);
		issue(OP_GET, 32'sd6, 32'sd0);

		for (int p = 0; p < PHASES; p++) begin
			drain();
			write_capacity(caps[p]);
			eff = (caps[p] < 1) ? 1 : ((caps[p] > ENTRIES) ? ENTRIES : caps[p]);
			pool_size = eff + $urandom_range(1, 6);
			for (int i = 0; i < pool_size; i++)
				key_pool[i] = $urandom;
			if (p % 3 == 0) begin
				key_pool[0] = 32'sh80000000;
				key_pool[1] = 32'sh7fffffff;
			end
			steady = (p % 4 == 3);
			pause_at = $urandom_range(10, ITEMS_PER_PHASE - 10);
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				if (i == pause_at)
					drain();
				op = ($urandom_range(0, 99) < 45) ? OP_PUT : OP_GET;
				if ($urandom_range(0, 99) < 88)
					k = key_pool[$urandom_range(0, pool_size - 1)];
				else
					k = $urandom;
				issue(op, k, pick_value());
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		$display("tb_top: %0d gets with %0d hits, %0d puts with %0d updates and %0d evictions",
			gets, get_hits, puts, put_hits, evictions);
		$display("tb_top: %0d capacity settings written, zero and 31 among them", settings_seen);
		if (failures == 0 && outstanding == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end
endmodule
